>>> hdl/pbfs_pkg.sv
package pbfs_pkg;

  localparam int unsigned FW_W  = 4;
  localparam int unsigned BIU_W = 9;
  localparam int unsigned IDX_W = 11;

  // Highest byte count the bytes_in_use register can express.
  localparam int unsigned MAX_USED_BYTES = (1 << BIU_W) - 1;

  localparam logic [FW_W-1:0]  FW_RESET  = 4'd8;
  localparam logic [BIU_W-1:0] BIU_RESET = 9'd256;

  localparam logic REG_FIELD_WIDTH  = 1'b0;
  localparam logic REG_BYTES_IN_USE = 1'b1;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_OOR   = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] field_index;
    logic [7:0]       field_value;
  } item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic clear;
    logic load_item;
    logic calc;
    logic rd_lo;
    logic lat_hi;
    logic lat_lo;
    logic merge;
    logic wr_hi;
    logic wr_lo;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic oor;
    logic is_write;
    logic has_next;
  } stat_t;

endpackage

>>> hdl/pbfs_ctrl.sv
module pbfs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pbfs_pkg::stat_t stat,
  output pbfs_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          done
);
  import pbfs_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CALC  = 4'd2;
  localparam logic [3:0] S_RD_HI = 4'd3;
  localparam logic [3:0] S_RD_LO = 4'd4;
  localparam logic [3:0] S_LAT   = 4'd5;
  localparam logic [3:0] S_MERGE = 4'd6;
  localparam logic [3:0] S_WR_HI = 4'd7;
  localparam logic [3:0] S_WR_LO = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = stat.oor ? S_DONE : S_RD_HI;
      end
      S_RD_HI: begin
        state_next = S_RD_LO;
      end
      S_RD_LO: begin
        cmd.rd_lo  = 1'b1;
        cmd.lat_hi = 1'b1;
        state_next = S_LAT;
      end
      S_LAT: begin
        cmd.lat_lo = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = stat.is_write ? S_WR_HI : S_DONE;
      end
      S_WR_HI: begin
        cmd.wr_hi  = 1'b1;
        state_next = stat.has_next ? S_WR_LO : S_DONE;
      end
      S_WR_LO: begin
        cmd.wr_lo  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

>>> hdl/pbfs_datapath.sv
module pbfs_datapath #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pbfs_pkg::cmd_t                    cmd,
  input  pbfs_pkg::item_t                   item,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [pbfs_pkg::BIU_W-1:0]        cfg_data,
  output pbfs_pkg::stat_t                   stat,
  output pbfs_pkg::result_t                 result
);
  import pbfs_pkg::*;

  localparam int unsigned Depth =
    (STORE_BYTES < MAX_USED_BYTES) ? STORE_BYTES : MAX_USED_BYTES;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [7:0] mem [Depth];

  logic [FW_W-1:0]  field_width;
  logic [BIU_W-1:0] bytes_in_use;
  logic [AW-1:0]    clr_cnt;

  item_t       item_r;
  logic [3:0]  w_r;
  logic [BIU_W-1:0] nb_r;
  logic [AW-1:0] n_r;
  logic [2:0]  h_r;
  logic        has_next_r;
  logic [7:0]  hi_r;
  logic [7:0]  lo_r;
  logic [15:0] win_r;
  result_t     res_r;
  logic [7:0]  rd_data;

  logic [3:0]       eff_w;
  logic [BIU_W-1:0] eff_nb;
  logic [14:0]      start_c;
  logic [11:0]      n_c;
  logic [11:0]      n_plus_c;
  logic             oor_c;
  logic             has_next_c;
  logic             trunc_c;
  logic [3:0]       shift_c;
  logic [7:0]       vmask_c;
  logic [15:0]      fmask_c;
  logic [15:0]      window_c;
  logic [15:0]      new_win_c;
  logic [7:0]       extract_c;
  logic [AW-1:0]    n_next_addr;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;
  logic [AW-1:0]    rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width  <= FW_RESET;
      bytes_in_use <= BIU_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FIELD_WIDTH) begin
        field_width <= cfg_data[FW_W-1:0];
      end else begin
        bytes_in_use <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign stat.clr_last = (clr_cnt == AW'(Depth - 1));

  always_comb begin
    if (field_width == 4'd0) begin
      eff_w = 4'd1;
    end else if (field_width > 4'd8) begin
      eff_w = 4'd8;
    end else begin
      eff_w = field_width;
    end
    if (32'(bytes_in_use) > Depth) begin
      eff_nb = BIU_W'(Depth);
    end else begin
      eff_nb = bytes_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= item;
      w_r    <= eff_w;
      nb_r   <= eff_nb;
    end
  end

  assign start_c    = 15'(w_r) * 15'(item_r.field_index);
  assign n_c        = start_c[14:3];
  assign n_plus_c   = n_c + 12'd1;
  assign oor_c      = start_c >= {3'b000, nb_r, 3'b000};
  assign has_next_c = n_plus_c < 12'(nb_r);
  assign trunc_c    = (5'(start_c[2:0]) + 5'(w_r) > 5'd8) && !has_next_c;

  assign stat.oor      = oor_c;
  assign stat.is_write = (item_r.kind == KIND_WRITE);
  assign stat.has_next = has_next_r;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      n_r        <= n_c[AW-1:0];
      h_r        <= start_c[2:0];
      has_next_r <= has_next_c;
      res_r.read_value <= 8'd0;
      if (oor_c) begin
        res_r.status <= ST_OOR;
      end else if (trunc_c) begin
        res_r.status <= ST_TRUNC;
      end else begin
        res_r.status <= ST_OK;
      end
    end else if (cmd.merge) begin
      win_r <= new_win_c;
      if (item_r.kind == KIND_READ) begin
        res_r.read_value <= extract_c;
      end
    end
  end

  assign n_next_addr = n_r + AW'(1);
  assign rd_addr     = (cmd.rd_lo && has_next_r) ? n_next_addr : n_r;

  always_ff @(posedge clk) begin
    if (cmd.lat_hi) begin
      hi_r <= rd_data;
    end
    if (cmd.lat_lo) begin
      lo_r <= has_next_r ? rd_data : 8'd0;
    end
  end

  assign shift_c   = 4'(5'd16 - 5'(h_r) - 5'(w_r));
  assign vmask_c   = 8'((9'd1 << w_r) - 9'd1);
  assign fmask_c   = {8'd0, vmask_c} << shift_c;
  assign window_c  = {hi_r, lo_r};
  assign new_win_c = (window_c & ~fmask_c)
                   | (({8'd0, item_r.field_value & vmask_c} << shift_c) & fmask_c);
  assign extract_c = 8'((window_c & fmask_c) >> shift_c);

  assign mem_we = cmd.clear | cmd.wr_hi | cmd.wr_lo;

  always_comb begin
    if (cmd.clear) begin
      wr_addr = clr_cnt;
      wr_data = 8'd0;
    end else if (cmd.wr_hi) begin
      wr_addr = n_r;
      wr_data = win_r[15:8];
    end else begin
      wr_addr = n_next_addr;
      wr_data = win_r[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign result = res_r;

endmodule

>>> hdl/packed_bit_field_store_top.sv
// Packed bit field store. Fields of 1 to 8 bits are packed most significant bit
// first into a byte store and are read or written one at a time. A transfer
// into the block takes place on a clock edge with start high and busy low, and
// each item yields exactly one result, shown on result for the single cycle in
// which done is high. The receiver cannot stall the block, so it must take the
// result in that cycle. The store has one write port and one read port, and the
// controller states set the item time: an out-of-range item passes through CALC
// and DONE, a read through CALC, RD_HI, RD_LO, LAT, MERGE and DONE, and a write
// adds WR_HI and WR_LO after MERGE, leaving out WR_LO when the field starts in
// the last byte in use. After reset the block clears min(STORE_BYTES, 511) bytes,
// one byte per cycle, while busy is high. Configuration writes are taken at any
// time but must only be issued while the block is idle.
module packed_bit_field_store_top #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  pbfs_pkg::item_t            item,
  output logic                       busy,
  output logic                       done,
  output pbfs_pkg::result_t          result,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [pbfs_pkg::BIU_W-1:0] cfg_data
);
  import pbfs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  pbfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pbfs_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

endmodule

>>> test/field_store_checker.sv
module field_store_checker
  import pbfs_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  item_t            item,
  input  logic             done,
  input  result_t          result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [BIU_W-1:0] cfg_data,
  output int               mismatches,
  output int               pending
);

  logic [FW_W-1:0]  width_reg;
  logic [BIU_W-1:0] used_reg;
  logic [7:0]       store_img [STORE_BYTES];
  result_t          expected_q [$];
  result_t          want;
  int               errs;

  function automatic result_t apply_field_access(input item_t it);
    int unsigned w;
    int unsigned nb;
    int unsigned first_bit;
    int unsigned byte_no;
    int unsigned bit_ofs;
    int unsigned shift;
    logic [15:0] window;
    logic [15:0] vmask;
    logic [15:0] fmask;
    logic        has_next;
    result_t     r;
    w = (width_reg == 0) ? 1 : (width_reg > 8) ? 8 : width_reg;
    nb = (used_reg > STORE_BYTES) ? STORE_BYTES : used_reg;
    first_bit = w * it.field_index;
    r.read_value = 8'h00;
    r.status = ST_OK;
    if (first_bit >= 8 * nb) begin
      r.status = ST_OOR;
      return r;
    end
    byte_no = first_bit >> 3;
    bit_ofs = first_bit & 7;
    has_next = (byte_no + 1) < nb;
    window = {store_img[byte_no], has_next ? store_img[byte_no + 1] : 8'h00};
    shift = 16 - bit_ofs - w;
    vmask = (16'h0001 << w) - 16'h0001;
    fmask = vmask << shift;
    if (bit_ofs + w > 8 && !has_next) begin
      r.status = ST_TRUNC;
    end
    if (it.kind == KIND_WRITE) begin
      window = (window & ~fmask) | (((16'(it.field_value) & vmask) << shift) & fmask);
      store_img[byte_no] = window[15:8];
      if (has_next) begin
        store_img[byte_no + 1] = window[7:0];
      end
    end else begin
      r.read_value = 8'((window & fmask) >> shift);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg = FW_RESET;
      used_reg = BIU_RESET;
      foreach (store_img[i]) store_img[i] = 8'h00;
      expected_q.delete();
      errs = 0;
      pending <= 0;
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FIELD_WIDTH) begin
          width_reg = cfg_data[FW_W-1:0];
        end else begin
          used_reg = cfg_data;
        end
      end
      if (start && !busy) begin
        expected_q.push_back(apply_field_access(item));
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          errs++;
          if (errs <= 50) begin
            $display("%0t: result transfer with none expected, actual read_value %0h status %0d",
                     $time, result.read_value, result.status);
          end
        end else begin
          want = expected_q.pop_front();
          if (want.read_value !== result.read_value) begin
            errs++;
            if (errs <= 50) begin
              $display("%0t: read_value expected %0h actual %0h",
                       $time, want.read_value, result.read_value);
            end
          end
          if (want.status !== result.status) begin
            errs++;
            if (errs <= 50) begin
              $display("%0t: status expected %0d actual %0d",
                       $time, want.status, result.status);
            end
          end
        end
      end
      pending <= expected_q.size();
      mismatches <= errs;
    end
  end

endmodule

>>> test/tb_packed_bit_field_store_top.sv
module tb_packed_bit_field_store_top;
  import pbfs_pkg::*;

  localparam int unsigned STORE_BYTES = 256;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  item_t            item = '0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = REG_FIELD_WIDTH;
  logic [BIU_W-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  result_t          result;
  int               mismatches;
  int               pending;

  logic             idle_on = 1'b1;
  int unsigned      fw_cur = 8;
  int unsigned      nb_cur = 256;

  packed_bit_field_store_top #(
    .STORE_BYTES(STORE_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  field_store_checker #(
    .STORE_BYTES(STORE_BYTES)
  ) i_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .item(item),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_item(input logic k, input int unsigned idx, input int unsigned val);
    int unsigned gap;
    if (idle_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= item_t'{kind: k, field_index: idx[IDX_W-1:0], field_value: val[7:0]};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic configure(input int unsigned w_data, input int unsigned nb);
    int unsigned wf;
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_FIELD_WIDTH;
    cfg_data <= w_data[BIU_W-1:0];
    @(posedge clk);
    cfg_index <= REG_BYTES_IN_USE;
    cfg_data <= nb[BIU_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    wf = w_data & 15;
    fw_cur = (wf == 0) ? 1 : (wf > 8) ? 8 : wf;
    nb_cur = (nb > STORE_BYTES) ? STORE_BYTES : nb;
  endtask

  // Mostly fields inside the used bytes, with a bias toward the last ones
  // where a field gets cut off.
  function automatic int unsigned pick_index();
    int unsigned last;
    if (nb_cur == 0 || $urandom_range(99) < 10) begin
      return $urandom_range(0, 2047);
    end
    last = (8 * nb_cur - 1) / fw_cur;
    if (last > 2047) begin
      last = 2047;
    end
    if ($urandom_range(99) < 10) begin
      return last - $urandom_range(0, (last < 2) ? last : 2);
    end
    return $urandom_range(0, last);
  endfunction

  initial begin
    int unsigned w;
    int unsigned nb;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_item(KIND_READ, 0, 0);
    send_item(KIND_WRITE, 0, 8'hff);
    send_item(KIND_READ, 0, 0);
    send_item(KIND_WRITE, 255, 8'ha5);
    send_item(KIND_READ, 255, 0);
    send_item(KIND_READ, 254, 0);
    send_item(KIND_READ, 256, 0);
    send_item(KIND_WRITE, 2047, 8'hff);
    send_item(KIND_READ, 2047, 0);

    configure(3, 2);
    send_item(KIND_WRITE, 2, 8'hfd);
    send_item(KIND_READ, 2, 0);
    send_item(KIND_WRITE, 5, 8'h07);
    send_item(KIND_READ, 5, 0);
    send_item(KIND_READ, 6, 0);
    send_item(KIND_READ, 4, 0);

    configure(0, 0);
    send_item(KIND_READ, 0, 0);
    send_item(KIND_WRITE, 0, 8'hff);

    configure(15, 511);
    send_item(KIND_WRITE, 255, 8'h3c);
    send_item(KIND_READ, 255, 0);
    send_item(KIND_READ, 256, 0);

    configure(1, 1);
    send_item(KIND_WRITE, 7, 8'h01);
    send_item(KIND_READ, 7, 0);
    send_item(KIND_READ, 8, 0);

    for (int ph = 0; ph < 32; ph++) begin
      if (ph < 8) begin
        w = ph + 1;
      end else if ($urandom_range(9) == 0) begin
        w = $urandom_range(0, 1) ? 0 : $urandom_range(9, 15);
      end else begin
        w = $urandom_range(1, 8);
      end
      case ($urandom_range(9))
        0: nb = $urandom_range(1, 2);
        1, 2, 3: nb = $urandom_range(3, 16);
        4, 5, 6: nb = $urandom_range(17, 64);
        7: nb = $urandom_range(65, 256);
        8: nb = 256;
        default: nb = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(257, 511);
      endcase
      if (ph == 31) begin
        w = 8;
        nb = 256;
      end
      configure(($urandom_range(0, 31) << 4) | w, nb);
      idle_on = !(ph >= 12 && ph < 16);
      for (int n = 0; n < 55; n++) begin
        if ($urandom_range(199) == 0) begin
          drain();
        end
        send_item(1'($urandom_range(0, 1)), pick_index(), $urandom_range(0, 255));
      end
    end

    start <= 1'b0;
    @(posedge clk);
    for (int c = 0; c < 2000 && pending != 0; c++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/pbfs_pkg.sv
hdl/pbfs_ctrl.sv
hdl/pbfs_datapath.sv
hdl/packed_bit_field_store_top.sv
test/field_store_checker.sv
test/tb_packed_bit_field_store_top.sv
